/* design/ols_pkg.sv */
package ols_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int CNT_OUT_W = 5;
  localparam int DEPTH_DEF = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
  // unused code, sent down the chain when an insert is dropped
  localparam logic [OP_W-1:0] OP_NOP    = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // command token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] nv;
    logic [DATA_W-1:0] carry;
    logic              found;
  } tok_t;

endpackage

/* design/ols_cell.sv */
module ols_cell #(
  parameter int DEPTH = ols_pkg::DEPTH_DEF,
  parameter int IDX   = 0,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [CW-1:0]              cnt,
  input  ols_pkg::tok_t              tin,
  input  logic [ols_pkg::DATA_W-1:0] below,
  output ols_pkg::tok_t              tout,
  output logic [ols_pkg::DATA_W-1:0] entry
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX1_C = CW'(IDX + 1);

  logic [ols_pkg::DATA_W-1:0] entry_next;
  ols_pkg::tok_t              tok_next;
  logic                       in_range;
  logic                       match;

  always_comb begin
    entry_next = entry;
    tok_next   = tin;
    in_range   = (IDX_C < cnt);
    match      = in_range && (entry == tin.key);
    if (tin.valid) begin
      case (tin.op)
        ols_pkg::OP_INSERT: begin
          // take the entry from above, pass ours down
          if (IDX_C <= cnt) begin
            entry_next     = tin.carry;
            tok_next.carry = entry;
          end
        end
        ols_pkg::OP_REMOVE: begin
          // at and after the first match, pull the neighbor up
          if ((tin.found || match) && (IDX1_C < cnt)) begin
            entry_next = below;
          end
          tok_next.found = tin.found || match;
        end
        ols_pkg::OP_SEARCH: begin
          tok_next.found = tin.found || match;
        end
        ols_pkg::OP_UPDATE: begin
          if (!tin.found && match) begin
            entry_next = tin.nv;
          end
          tok_next.found = tin.found || match;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else begin
      tout <= tok_next;
    end
  end

endmodule

/* design/ols_ctrl.sv */
module ols_ctrl #(
  parameter int DEPTH = ols_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ols_pkg::OP_W-1:0]      opcode,
  input  logic signed [ols_pkg::DATA_W-1:0] key,
  input  logic signed [ols_pkg::DATA_W-1:0] new_value,
  output ols_pkg::tok_t                 head,
  input  ols_pkg::tok_t                 tail,
  output logic [CW-1:0]                 cnt,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic                          full_flag,
  output logic [ols_pkg::CNT_OUT_W-1:0] entry_count
);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  ols_pkg::state_t            state, state_next;
  logic [ols_pkg::OP_W-1:0]   op;
  logic                       dropped;
  logic                       accept;
  logic                       is_full;

  assign accept  = in_valid && !in_stall;
  assign is_full = (cnt == DEPTH_C);

  always_comb begin
    state_next = state;
    case (state)
      ols_pkg::ST_IDLE: if (in_valid) state_next = ols_pkg::ST_WALK;
      ols_pkg::ST_WALK: if (tail.valid) state_next = ols_pkg::ST_DONE;
      ols_pkg::ST_DONE: if (!out_stall) state_next = ols_pkg::ST_IDLE;
      default:          state_next = ols_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != ols_pkg::ST_IDLE);
    out_valid   = (state == ols_pkg::ST_DONE);
    entry_count = ols_pkg::CNT_OUT_W'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ols_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // launch register at the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= accept;
      if (accept) begin
        head.op    <= (opcode == ols_pkg::OP_INSERT && is_full) ? ols_pkg::OP_NOP : opcode;
        head.key   <= key;
        head.nv    <= new_value;
        head.carry <= key;
        head.found <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= opcode;
      dropped <= (opcode == ols_pkg::OP_INSERT) && is_full;
    end
  end

  // count and result settle when the token leaves the last cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ols_pkg::ST_WALK && tail.valid) begin
      case (op)
        ols_pkg::OP_INSERT: if (!dropped) cnt <= cnt + ONE_C;
        ols_pkg::OP_REMOVE: if (tail.found) cnt <= cnt - ONE_C;
        ols_pkg::OP_CLEAR:  cnt <= '0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ols_pkg::ST_WALK && tail.valid) begin
      case (op)
        ols_pkg::OP_INSERT: begin
          hit       <= !dropped;
          full_flag <= dropped;
        end
        ols_pkg::OP_REMOVE, ols_pkg::OP_SEARCH, ols_pkg::OP_UPDATE: begin
          hit       <= tail.found;
          full_flag <= 1'b0;
        end
        default: begin
          hit       <= 1'b0;
          full_flag <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* design/ordered_list_store_top.sv */
// channel | valid     | stall     | payload
// --------+-----------+-----------+----------------------------
// in      | in_valid  | in_stall  | opcode, key, new_value
// out     | out_valid | out_stall | hit, full_flag, entry_count
//
// One command at a time: after the input transfer the launch register takes
// it and the token moves one cell per clock along the row; out_valid rises
// once the token has left the last cell.
// rst (sync, active high) empties the list; entries need no clearing.
// A stalled result holds; in_stall stays high until it is transferred out.
module ordered_list_store_top #(
  parameter int DEPTH = ols_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ols_pkg::OP_W-1:0]          opcode,
  input  logic signed [ols_pkg::DATA_W-1:0] key,
  input  logic signed [ols_pkg::DATA_W-1:0] new_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic                              full_flag,
  output logic [ols_pkg::CNT_OUT_W-1:0]     entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  // tok[i] enters cell i; tok[DEPTH] leaves the last cell
  ols_pkg::tok_t              tok [DEPTH+1];
  logic [ols_pkg::DATA_W-1:0] ent [DEPTH];
  logic [DEPTH:0]             tok_v;
  logic [CW-1:0]              cnt;

  ols_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .key         (key),
    .new_value   (new_value),
    .head        (tok[0]),
    .tail        (tok[DEPTH]),
    .cnt         (cnt),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .full_flag   (full_flag),
    .entry_count (entry_count)
  );

  // row of cells; each but the last sees its lower neighbor for the remove shift (the last sees itself)
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ols_pkg::DATA_W-1:0] below;
    if (i == DEPTH - 1) begin : g_last
      assign below = ent[i];
    end else begin : g_mid
      assign below = ent[i+1];
    end

    ols_cell #(
      .DEPTH (DEPTH),
      .IDX   (i),
      .CW    (CW)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .cnt   (cnt),
      .tin   (tok[i]),
      .below (below),
      .tout  (tok[i+1]),
      .entry (ent[i])
    );
  end

  for (genvar j = 0; j <= DEPTH; j++) begin : g_tv
    assign tok_v[j] = tok[j].valid;
  end

  // only one command in flight along the row
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_v))
    else $error("more than one token in the cell row");

  // no token in flight while a result waits
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tok_v == '0))
    else $error("token moving while result is pending");

  // count never exceeds the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above capacity");

  // a dropped insert is never a hit and leaves the count at capacity
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && full_flag) |-> (!hit && cnt == CW'(DEPTH)))
    else $error("full flag inconsistent with hit or count");

endmodule
